// File: rtl/acc_pkg.sv
// package: payload types, field widths and codes for the box containment classifier
package acc_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int RADIUS_WIDTH = COORD_WIDTH - 1;
  localparam int CFG_INDEX_WIDTH = 3;

  localparam logic [1:0] CMD_POINT = 2'd0;
  localparam logic [1:0] CMD_BOX = 2'd1;
  localparam logic [1:0] CMD_SPHERE = 2'd2;

  localparam logic [1:0] VERDICT_OUTSIDE = 2'd0;
  localparam logic [1:0] VERDICT_INTERSECTS = 2'd1;
  localparam logic [1:0] VERDICT_INSIDE = 2'd2;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOX_MIN_X = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOX_MIN_Y = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOX_MIN_Z = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOX_MAX_X = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOX_MAX_Y = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOX_MAX_Z = 3'd5;

  typedef struct packed {
    logic [1:0] cmd;
    logic signed [COORD_WIDTH-1:0] p_x;
    logic signed [COORD_WIDTH-1:0] p_y;
    logic signed [COORD_WIDTH-1:0] p_z;
    logic signed [COORD_WIDTH-1:0] q_x;
    logic signed [COORD_WIDTH-1:0] q_y;
    logic signed [COORD_WIDTH-1:0] q_z;
    logic [RADIUS_WIDTH-1:0] radius;
  } query_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic overlaps;
  } result_t;

endpackage

// File: rtl/aabb_containment_classifier.sv
// top level: four-stage pipelined point, box and sphere test against a configured box
//
// One query enters per clock while query_stall is low; its result passes through
// stages one to three into the output register, the fourth register stage. Stage
// one does the per-axis compares and clamped distances, stage two the four squarings
// (three distances 32x32, radius 31x31), stage three the distance sum, stage four the
// sum-versus-radius compare and the verdict. The whole pipeline holds as one while
// a result sits in the output register under stall, so query_stall follows
// result_stall only in that case. The box registers are written through
// cfg_we/cfg_index/cfg_data; indexes 0..2 are the lower bounds x, y, z and 3..5 the
// upper bounds, other indexes are ignored. Reset leaves an empty box, so every
// query answers outside until the box is written.
module aabb_containment_classifier
  import acc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [COORD_WIDTH-1:0]     cfg_data,
  input  logic                       query_valid,
  output logic                       query_stall,
  input  query_t                     query,
  output logic                       result_valid,
  input  logic                       result_stall,
  output result_t                    result
);

  localparam int EXT_W = COORD_WIDTH + 2;
  localparam int SQ_W = 2 * COORD_WIDTH;
  localparam int SUM_W = SQ_W + 2;
  localparam int RSQ_W = 2 * RADIUS_WIDTH;
  localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic [1:0] cmd;
    logic       empty;
    logic       pt_out;
    logic       disjoint;
    logic       box_partial;
    logic       sph_partial;
  } flags_t;

  // box registers
  logic signed [COORD_WIDTH-1:0] bmin [3];
  logic signed [COORD_WIDTH-1:0] bmax [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        bmin[i] <= COORD_MAX;
        bmax[i] <= COORD_MIN;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BOX_MIN_X: bmin[0] <= cfg_data;
        REG_BOX_MIN_Y: bmin[1] <= cfg_data;
        REG_BOX_MIN_Z: bmin[2] <= cfg_data;
        REG_BOX_MAX_X: bmax[0] <= cfg_data;
        REG_BOX_MAX_Y: bmax[1] <= cfg_data;
        REG_BOX_MAX_Z: bmax[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  assign en = !(result_valid && result_stall);
  assign query_stall = !en;

  // stage 1: compares and clamped distances
  logic signed [COORD_WIDTH-1:0] p [3];
  logic signed [COORD_WIDTH-1:0] q [3];
  flags_t flags1_next;
  logic [COORD_WIDTH-1:0] d1_next [3];

  always_comb begin
    logic signed [EXT_W-1:0] pe;
    logic signed [EXT_W-1:0] re;
    logic signed [EXT_W-1:0] mn;
    logic signed [EXT_W-1:0] mx;
    logic signed [EXT_W-1:0] diff;
    p[0] = query.p_x;
    p[1] = query.p_y;
    p[2] = query.p_z;
    q[0] = query.q_x;
    q[1] = query.q_y;
    q[2] = query.q_z;
    re = EXT_W'(query.radius);
    flags1_next = '0;
    flags1_next.cmd = query.cmd;
    for (int i = 0; i < 3; i++) begin
      pe = EXT_W'(p[i]);
      mn = EXT_W'(bmin[i]);
      mx = EXT_W'(bmax[i]);
      if (bmin[i] > bmax[i]) flags1_next.empty = 1'b1;
      if (p[i] < bmin[i] || p[i] > bmax[i]) flags1_next.pt_out = 1'b1;
      if (q[i] < bmin[i] || p[i] > bmax[i]) flags1_next.disjoint = 1'b1;
      if (p[i] < bmin[i] || q[i] > bmax[i]) flags1_next.box_partial = 1'b1;
      if ((pe - re) < mn || (pe + re) > mx) flags1_next.sph_partial = 1'b1;
      if (p[i] < bmin[i]) begin
        diff = mn - pe;
      end else if (p[i] > bmax[i]) begin
        diff = pe - mx;
      end else begin
        diff = '0;
      end
      // clamped distance always fits the coordinate width unsigned
      d1_next[i] = diff[COORD_WIDTH-1:0];
    end
  end

  logic v1, v2, v3;
  flags_t flags1, flags2, flags3;
  logic [COORD_WIDTH-1:0] d1 [3];
  logic [RADIUS_WIDTH-1:0] r1;
  logic [SQ_W-1:0] sq2 [3];
  logic [RSQ_W-1:0] rsq2, rsq3;
  logic [SUM_W-1:0] sum3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      result_valid <= 1'b0;
    end else if (en) begin
      v1 <= query_valid;
      v2 <= v1;
      v3 <= v2;
      result_valid <= v3;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1
      flags1 <= flags1_next;
      d1 <= d1_next;
      r1 <= query.radius;
      // stage 2: squares
      flags2 <= flags1;
      for (int i = 0; i < 3; i++) begin
        sq2[i] <= SQ_W'(d1[i]) * SQ_W'(d1[i]);
      end
      rsq2 <= RSQ_W'(r1) * RSQ_W'(r1);
      // stage 3: distance sum
      flags3 <= flags2;
      sum3 <= SUM_W'(sq2[0]) + SUM_W'(sq2[1]) + SUM_W'(sq2[2]);
      rsq3 <= rsq2;
    end
  end

  // stage 4: verdict into the output register
  result_t result_next;

  always_comb begin
    result_next.verdict = VERDICT_OUTSIDE;
    if (!flags3.empty) begin
      case (flags3.cmd)
        CMD_POINT: begin
          result_next.verdict = flags3.pt_out ? VERDICT_OUTSIDE : VERDICT_INSIDE;
        end
        CMD_BOX: begin
          if (flags3.disjoint) result_next.verdict = VERDICT_OUTSIDE;
          else if (flags3.box_partial) result_next.verdict = VERDICT_INTERSECTS;
          else result_next.verdict = VERDICT_INSIDE;
        end
        CMD_SPHERE: begin
          if (sum3 > SUM_W'(rsq3)) result_next.verdict = VERDICT_OUTSIDE;
          else if (flags3.sph_partial) result_next.verdict = VERDICT_INTERSECTS;
          else result_next.verdict = VERDICT_INSIDE;
        end
        default: result_next.verdict = VERDICT_OUTSIDE;
      endcase
    end
    result_next.overlaps = (result_next.verdict != VERDICT_OUTSIDE);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= result_next;
    end
  end

endmodule

// File: rtl/acc_checker.sv
// checker: port-level properties of the box containment classifier, bound to the top level
module acc_checker
  import acc_pkg::*;
(
  input logic                       clk,
  input logic                       rst,
  input logic                       query_stall,
  input logic                       result_valid,
  input logic                       result_stall,
  input result_t                    result
);

  // overlaps flag agrees with the verdict
  a_overlaps_match: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.overlaps == (result.verdict != VERDICT_OUTSIDE)))
    else $error("overlaps disagrees with verdict");

  // verdict code stays in range
  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.verdict == VERDICT_OUTSIDE ||
                      result.verdict == VERDICT_INTERSECTS ||
                      result.verdict == VERDICT_INSIDE))
    else $error("unused verdict code");

  // input backpressure only while a result is held under stall
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    query_stall |-> (result_valid && result_stall))
    else $error("query stalled without a held result");

  // a stalled item holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled item changed");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind aabb_containment_classifier acc_checker u_acc_checker (.*);

// File: test/tb_top.sv
// testbench: random and directed point, box and sphere queries against a predicted classifier
module tb_top;
  import acc_pkg::*;

  localparam longint CMAX = 64'sd2147483647;
  localparam longint CMIN = -64'sd2147483648;
  localparam int ONE = 65536;
  localparam int RMAX = 2147483647;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UNMAPPED_A = 3'd6;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UNMAPPED_B = 3'd7;
  localparam int DRAIN_CYCLES = 12;
  localparam int QUIET_LIMIT = 2000;

  logic clk;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [COORD_WIDTH-1:0] cfg_data = '0;
  logic query_valid = 1'b0;
  logic query_stall;
  query_t query = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;

  // box as the classifier should hold it
  longint box_lo[3];
  longint box_hi[3];

  query_t pending_queries[$];
  result_t due_results[$];
  int mismatches = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_tick = 0;
  int stall_mode = 0;
  int quiet_cycles = 0;
  result_t want;

  aabb_containment_classifier i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .query_valid(query_valid),
    .query_stall(query_stall),
    .query(query),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic result_t classify_query(query_t qi);
    longint p[3];
    longint q[3];
    longint r;
    logic [71:0] dist_sum;
    logic [71:0] d;
    logic [71:0] rr;
    bit empty;
    bit outside;
    bit disjoint;
    bit partial;
    int i;
    result_t res;
    p[0] = $signed(qi.p_x);
    p[1] = $signed(qi.p_y);
    p[2] = $signed(qi.p_z);
    q[0] = $signed(qi.q_x);
    q[1] = $signed(qi.q_y);
    q[2] = $signed(qi.q_z);
    r = qi.radius;
    rr = r;
    empty = 0;
    outside = 0;
    disjoint = 0;
    partial = 0;
    dist_sum = '0;
    for (i = 0; i < 3; i++) begin
      if (box_lo[i] > box_hi[i]) empty = 1;
    end
    res.verdict = VERDICT_OUTSIDE;
    if (!empty) begin
      case (qi.cmd)
        CMD_POINT: begin
          for (i = 0; i < 3; i++) begin
            if (p[i] < box_lo[i] || p[i] > box_hi[i]) outside = 1;
          end
          res.verdict = outside ? VERDICT_OUTSIDE : VERDICT_INSIDE;
        end
        CMD_BOX: begin
          for (i = 0; i < 3; i++) begin
            if (q[i] < box_lo[i] || p[i] > box_hi[i]) disjoint = 1;
            if (p[i] < box_lo[i] || q[i] > box_hi[i]) partial = 1;
          end
          res.verdict = disjoint ? VERDICT_OUTSIDE :
                        (partial ? VERDICT_INTERSECTS : VERDICT_INSIDE);
        end
        CMD_SPHERE: begin
          for (i = 0; i < 3; i++) begin
            d = '0;
            if (p[i] < box_lo[i]) d = box_lo[i] - p[i];
            else if (p[i] > box_hi[i]) d = p[i] - box_hi[i];
            dist_sum = dist_sum + d * d;
            if (p[i] - r < box_lo[i] || p[i] + r > box_hi[i]) partial = 1;
          end
          if (dist_sum > rr * rr) res.verdict = VERDICT_OUTSIDE;
          else res.verdict = partial ? VERDICT_INTERSECTS : VERDICT_INSIDE;
        end
        default: res.verdict = VERDICT_OUTSIDE;
      endcase
    end
    res.overlaps = (res.verdict != VERDICT_OUTSIDE);
    return res;
  endfunction

  function automatic query_t query_of(logic [1:0] c, int px, int py, int pz,
                                      int qx, int qy, int qz, int r);
    query_t qi;
    qi.cmd = c;
    qi.p_x = px;
    qi.p_y = py;
    qi.p_z = pz;
    qi.q_x = qx;
    qi.q_y = qy;
    qi.q_z = qz;
    qi.radius = r[RADIUS_WIDTH-1:0];
    return qi;
  endfunction

  // coordinate around the current box on one axis: faces, just past them, interior, extremes, anywhere
  function automatic logic [COORD_WIDTH-1:0] coord_near(int ax);
    longint lo;
    longint hi;
    longint v;
    logic [63:0] rnd;
    lo = box_lo[ax];
    hi = box_hi[ax];
    rnd = {$urandom(), $urandom()};
    case ($urandom_range(0, 9))
      0: v = lo;
      1: v = hi;
      2: v = lo - longint'($urandom_range(1, 1 << $urandom_range(0, 20)));
      3: v = hi + longint'($urandom_range(1, 1 << $urandom_range(0, 20)));
      4, 5, 6: v = (hi > lo) ? lo + longint'(rnd % (hi - lo + 1)) : lo;
      7: v = $urandom_range(0, 1) ? CMAX : CMIN;
      default: v = $signed($urandom());
    endcase
    if (v < CMIN) v = CMIN;
    if (v > CMAX) v = CMAX;
    return v[COORD_WIDTH-1:0];
  endfunction

  function automatic query_t make_query();
    query_t qi;
    logic [COORD_WIDTH-1:0] a;
    logic [COORD_WIDTH-1:0] b;
    logic [63:0] rnd;
    longint half;
    longint r;
    int i;
    int pick;
    pick = $urandom_range(0, 19);
    qi.cmd = (pick == 0) ? CMD_UNUSED : (pick % 3 == 0) ? CMD_POINT :
             (pick % 3 == 1) ? CMD_BOX : CMD_SPHERE;
    qi.p_x = coord_near(0);
    qi.p_y = coord_near(1);
    qi.p_z = coord_near(2);
    qi.q_x = $urandom();
    qi.q_y = $urandom();
    qi.q_z = $urandom();
    qi.radius = RADIUS_WIDTH'($urandom());
    if (qi.cmd == CMD_BOX) begin
      for (i = 0; i < 3; i++) begin
        a = coord_near(i);
        b = coord_near(i);
        // mostly well-ordered query boxes, some left inverted
        if ($signed(a) > $signed(b) && $urandom_range(0, 7) != 0) begin
          a = a ^ b;
          b = a ^ b;
          a = a ^ b;
        end
        case (i)
          0: begin qi.p_x = a; qi.q_x = b; end
          1: begin qi.p_y = a; qi.q_y = b; end
          default: begin qi.p_z = a; qi.q_z = b; end
        endcase
      end
    end else if (qi.cmd == CMD_SPHERE) begin
      half = CMAX;
      for (i = 0; i < 3; i++) begin
        if ((box_hi[i] - box_lo[i]) / 2 < half) half = (box_hi[i] - box_lo[i]) / 2;
      end
      if (half < 0) half = 0;
      rnd = {$urandom(), $urandom()};
      case ($urandom_range(0, 7))
        0: r = 0;
        1: r = RMAX;
        2: r = $urandom_range(0, 1 << $urandom_range(0, 30));
        3: r = $urandom() & RMAX;
        4, 5: r = longint'(rnd % (half / 4 + 1));
        default: r = longint'(rnd % (half + 1));
      endcase
      qi.radius = r[RADIUS_WIDTH-1:0];
    end
    return qi;
  endfunction

  task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, longint val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[COORD_WIDTH-1:0];
    case (idx)
      REG_BOX_MIN_X: box_lo[0] = val;
      REG_BOX_MIN_Y: box_lo[1] = val;
      REG_BOX_MIN_Z: box_lo[2] = val;
      REG_BOX_MAX_X: box_hi[0] = val;
      REG_BOX_MAX_Y: box_hi[1] = val;
      REG_BOX_MAX_Z: box_hi[2] = val;
      default: ;
    endcase
  endtask

  task automatic load_box(longint x0, longint y0, longint z0,
                          longint x1, longint y1, longint z1);
    write_reg(REG_BOX_MIN_X, x0);
    write_reg(REG_BOX_MIN_Y, y0);
    write_reg(REG_BOX_MIN_Z, z0);
    write_reg(REG_BOX_MAX_X, x1);
    write_reg(REG_BOX_MAX_Y, y1);
    write_reg(REG_BOX_MAX_Z, z1);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_box();
    longint lo[3];
    longint hi[3];
    longint a;
    longint b;
    int i;
    for (i = 0; i < 3; i++) begin
      a = $signed($urandom());
      case ($urandom_range(0, 2))
        0: b = a + longint'($urandom_range(0, 1 << $urandom_range(0, 24)));
        default: b = $signed($urandom());
      endcase
      if (b > CMAX) b = CMAX;
      // now and then leave an axis empty
      if (a > b && $urandom_range(0, 11) != 0) begin
        lo[i] = b;
        hi[i] = a;
      end else begin
        lo[i] = a;
        hi[i] = b;
      end
    end
    load_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endtask

  task automatic add_random(int n);
    repeat (n) pending_queries.push_back(make_query());
  endtask

  // wait until every query has come back, then let the pipeline go quiet
  task automatic settle();
    do @(posedge clk);
    while (pending_queries.size() != 0 || query_valid || due_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // sender: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      query_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (query_valid && !query_stall) begin
        due_results.push_back(classify_query(query));
      end
      if (!query_valid || !query_stall) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
        if (gap_left > 0 || pending_queries.size() == 0) begin
          if (gap_left > 0) gap_left--;
          query_valid <= 1'b0;
        end else begin
          query <= pending_queries.pop_front();
          query_valid <= 1'b1;
          burst_left--;
        end
      end
    end
  end

  // receiver: checks each result and stalls in modes that are picked at random
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (due_results.size() == 0) begin
          mismatches++;
          $display("%0t: result expected none got verdict %0d overlaps %0d",
                   $time, result.verdict, result.overlaps);
        end else begin
          want = due_results.pop_front();
          if (result.verdict !== want.verdict) begin
            mismatches++;
            $display("%0t: verdict expected %0d got %0d", $time, want.verdict,
                     result.verdict);
          end
          if (result.overlaps !== want.overlaps) begin
            mismatches++;
            $display("%0t: overlaps expected %0d got %0d", $time, want.overlaps,
                     result.overlaps);
          end
        end
      end
      stall_tick++;
      if (stall_tick % 48 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: result_stall <= 1'b0;
        1: result_stall <= ($urandom_range(0, 9) < 3);
        2: result_stall <= (stall_tick % 4 == 0);
        default: result_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (query_valid && !query_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("aabb_containment_classifier verification failed");
      $finish;
    end
  end

  initial begin
    box_lo = '{CMAX, CMAX, CMAX};
    box_hi = '{CMIN, CMIN, CMIN};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // empty box out of reset: everything is outside
    pending_queries.push_back(query_of(CMD_POINT, 0, 0, 0, 0, 0, 0, 0));
    pending_queries.push_back(query_of(CMD_BOX, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0));
    pending_queries.push_back(query_of(CMD_SPHERE, 0, 0, 0, 0, 0, 0, RMAX));
    pending_queries.push_back(query_of(CMD_UNUSED, 0, 0, 0, 0, 0, 0, 0));
    add_random(30);
    settle();

    load_box(-10 * ONE, -20 * ONE, -30 * ONE, 10 * ONE, 20 * ONE, 30 * ONE);
    pending_queries.push_back(query_of(CMD_POINT, 0, 0, 0, 0, 0, 0, 0));
    pending_queries.push_back(query_of(CMD_POINT, -10 * ONE, -20 * ONE, -30 * ONE,
                                       0, 0, 0, 0));
    pending_queries.push_back(query_of(CMD_POINT, 10 * ONE, 20 * ONE, 30 * ONE, 0, 0, 0, 0));
    pending_queries.push_back(query_of(CMD_POINT, 10 * ONE + 1, 0, 0, 0, 0, 0, 0));
    pending_queries.push_back(query_of(CMD_POINT, CMIN, CMIN, CMIN, 0, 0, 0, 0));
    pending_queries.push_back(query_of(CMD_POINT, CMAX, CMAX, CMAX, 0, 0, 0, 0));
    pending_queries.push_back(query_of(CMD_BOX, -ONE, -ONE, -ONE, ONE, ONE, ONE, 0));
    pending_queries.push_back(query_of(CMD_BOX, -10 * ONE, -20 * ONE, -30 * ONE,
                                       10 * ONE, 20 * ONE, 30 * ONE, 0));
    pending_queries.push_back(query_of(CMD_BOX, 5 * ONE, 0, 0, 15 * ONE, ONE, ONE, 0));
    pending_queries.push_back(query_of(CMD_BOX, 11 * ONE, 0, 0, 12 * ONE, ONE, ONE, 0));
    // query box sharing a face with the configured one
    pending_queries.push_back(query_of(CMD_BOX, 10 * ONE, 0, 0, 11 * ONE, ONE, ONE, 0));
    pending_queries.push_back(query_of(CMD_BOX, ONE, ONE, ONE, -ONE, -ONE, -ONE, 0));
    pending_queries.push_back(query_of(CMD_BOX, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 0));
    pending_queries.push_back(query_of(CMD_BOX, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0));
    pending_queries.push_back(query_of(CMD_SPHERE, 0, 0, 0, 0, 0, 0, ONE));
    pending_queries.push_back(query_of(CMD_SPHERE, 0, 0, 0, 0, 0, 0, 10 * ONE));
    pending_queries.push_back(query_of(CMD_SPHERE, 0, 0, 0, 0, 0, 0, 10 * ONE + 1));
    // centre outside at exactly the radius, then just beyond it
    pending_queries.push_back(query_of(CMD_SPHERE, 13 * ONE, 0, 0, 0, 0, 0, 3 * ONE));
    pending_queries.push_back(query_of(CMD_SPHERE, 13 * ONE, 0, 0, 0, 0, 0, 3 * ONE - 1));
    pending_queries.push_back(query_of(CMD_SPHERE, CMIN, CMIN, CMIN, 0, 0, 0, RMAX));
    pending_queries.push_back(query_of(CMD_SPHERE, 0, 0, 0, 0, 0, 0, 0));
    pending_queries.push_back(query_of(CMD_SPHERE, 0, 0, 0, 0, 0, 0, RMAX));
    pending_queries.push_back(query_of(CMD_UNUSED, 0, 0, 0, 0, 0, 0, 0));
    add_random(70);
    settle();

    load_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
    pending_queries.push_back(query_of(CMD_POINT, CMIN, CMIN, CMIN, 0, 0, 0, 0));
    pending_queries.push_back(query_of(CMD_POINT, CMAX, CMAX, CMAX, 0, 0, 0, 0));
    pending_queries.push_back(query_of(CMD_BOX, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0));
    pending_queries.push_back(query_of(CMD_SPHERE, CMIN, CMIN, CMIN, 0, 0, 0, RMAX));
    add_random(50);
    settle();

    // single-point box in the far corner: largest clamped distances
    load_box(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
    pending_queries.push_back(query_of(CMD_POINT, CMAX, CMAX, CMAX, 0, 0, 0, 0));
    pending_queries.push_back(query_of(CMD_SPHERE, CMIN, CMIN, CMIN, 0, 0, 0, RMAX));
    pending_queries.push_back(query_of(CMD_SPHERE, CMAX, CMAX, CMAX, 0, 0, 0, 0));
    add_random(50);
    settle();

    load_box(CMIN, CMIN, 0, CMIN, CMAX, 0);
    add_random(50);
    settle();

    // y axis empty only, unmapped indexes written too
    write_reg(CFG_UNMAPPED_A, $urandom());
    write_reg(CFG_UNMAPPED_B, $urandom());
    load_box(-ONE, ONE, -ONE, ONE, 0, ONE);
    add_random(50);
    settle();

    repeat (5) begin
      random_box();
      add_random(60);
      settle();
    end

    if (mismatches == 0) begin
      $display("aabb_containment_classifier verification clean");
    end else begin
      $display("aabb_containment_classifier verification failed");
    end
    $finish;
  end

endmodule
